// ----- hw/rtl/rle_pkg.sv -----
// Shared constants, command codes and types of the run-length encoder.
package rle_pkg;

   localparam int TOKEN_MAX     = 128;
   localparam int MIN_RUN_LIMIT = 16;
   localparam int LITERAL_DEPTH = 144;
   localparam int LANES         = 8;

   localparam int BYTE_W  = 8;
   localparam int HDR_W   = BYTE_W - 1;
   localparam int MR_W    = 5;
   localparam int LC_W    = 4;
   localparam int CNT_W   = $clog2(TOKEN_MAX + 1);
   localparam int LIT_AW  = $clog2(LITERAL_DEPTH);
   localparam int LANE_AW = (LANES > 1) ? $clog2(LANES) : 1;

   // command queue between front and back, power-of-two depth
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   localparam logic [MR_W-1:0]   MIN_RUN_RESET = 5'd3;
   localparam logic [BYTE_W-1:0] REPEAT_FLAG   = 8'h80;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_REPEAT = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;
   localparam logic [1:0] OP_END    = 2'd3;

   typedef logic [LANES-1:0][BYTE_W-1:0] lanes_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [BYTE_W-1:0] value;
      logic [BYTE_W-1:0] aux;
      logic              eos;
   } cmd_type;

endpackage

// ----- hw/rtl/rle_cmd_fifo.sv -----
// Short command queue between the classifying front and the emitting back.
module rle_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rle_pkg::cmd_type push_cmd,
   input  logic             pop,
   output rle_pkg::cmd_type head,
   output logic             not_empty,
   output logic             room
);
   import rle_pkg::*;

   cmd_type         slot_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign room      = count_ff != (Q_AW + 1)'(Q_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && room;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- hw/rtl/rle_front.sv -----
// Front of the encoder: run tracking, classification and command issue.
module rle_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [rle_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                       req_end_of_stream,
   input  logic                       csr_wr_en,
   input  logic [rle_pkg::MR_W-1:0]   csr_wr_data,
   output logic                       cmd_push,
   output rle_pkg::cmd_type           cmd_out,
   input  logic                       cmd_room
);
   import rle_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECIDE = 4'd1;
   localparam logic [3:0] S_CLOSE  = 4'd2;
   localparam logic [3:0] S_LFLUSH = 4'd3;
   localparam logic [3:0] S_NEWRUN = 4'd4;
   localparam logic [3:0] S_EFLUSH = 4'd5;
   localparam logic [3:0] S_ECHUNK = 4'd6;
   localparam logic [3:0] S_FINAL  = 4'd7;
   localparam logic [3:0] S_END    = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [MR_W-1:0]   min_run_ff;
   logic [BYTE_W-1:0] data_ff;
   logic              eos_ff;
   logic              ret_final_ff, ret_final_in;
   logic [BYTE_W-1:0] rv_ff, rv_in;
   logic [CNT_W-1:0]  rl_ff, rl_in;
   logic              rep_ff, rep_in;
   logic [CNT_W-1:0]  lc_ff, lc_in;

   logic [CNT_W-1:0]  eff_min;
   logic [CNT_W-1:0]  rl_inc;
   logic [CNT_W-1:0]  room_left;
   logic [CNT_W-1:0]  take_n;
   logic [CNT_W-1:0]  lc_sum;
   logic              iss;
   logic              go;
   logic              accept;
   logic [3:0]        after_state;

   function automatic logic [BYTE_W-1:0] repeat_header(input logic [CNT_W-1:0] count);
      logic [CNT_W-1:0] less;
      less = count - 1'b1;
      return REPEAT_FLAG | {1'b0, HDR_W'(less)};
   endfunction

   // clamp the register into the legal run range
   always_comb begin
      if (min_run_ff == '0) begin
         eff_min = CNT_W'(1);
      end else if (min_run_ff > MR_W'(MIN_RUN_LIMIT)) begin
         eff_min = CNT_W'(MIN_RUN_LIMIT);
      end else begin
         eff_min = CNT_W'(min_run_ff);
      end
   end

   assign rl_inc      = rl_ff + 1'b1;
   assign room_left   = CNT_W'(TOKEN_MAX) - lc_ff;
   assign take_n      = (rl_ff < room_left) ? rl_ff : room_left;
   assign lc_sum      = lc_ff + take_n;
   assign after_state = eos_ff ? S_CLOSE : S_END;

   assign req_stall = !((state_ff == S_IDLE) || ((state_ff == S_END) && cmd_room));
   assign accept    = req_valid && !req_stall;
   assign go        = !iss || cmd_room;
   assign cmd_push  = iss && cmd_room;

   always_comb begin
      state_in     = state_ff;
      ret_final_in = ret_final_ff;
      rv_in        = rv_ff;
      rl_in        = rl_ff;
      rep_in       = rep_ff;
      lc_in        = lc_ff;
      iss          = 1'b0;
      cmd_out      = '{op: OP_END, value: rv_ff, aux: '0, eos: eos_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if ((rl_ff != '0 || rep_ff) && data_ff == rv_ff) begin
               rl_in = rl_inc;
               if (rep_ff) begin
                  state_in = S_ECHUNK;
               end else if (rl_inc >= eff_min) begin
                  rep_in   = 1'b1;
                  state_in = S_EFLUSH;
               end else begin
                  ret_final_in = 1'b1;
                  state_in     = after_state;
               end
            end else begin
               ret_final_in = 1'b0;
               state_in     = S_CLOSE;
            end
         end
         S_CLOSE: begin
            if (rep_ff) begin
               iss     = rl_ff != '0;
               cmd_out = '{op: OP_REPEAT, value: rv_ff, aux: repeat_header(rl_ff),
                           eos: eos_ff};
               if (go) begin
                  rl_in    = '0;
                  rep_in   = 1'b0;
                  state_in = ret_final_ff ? S_FINAL : S_NEWRUN;
               end
            end else if (rl_ff == '0) begin
               state_in = ret_final_ff ? S_FINAL : S_NEWRUN;
            end else begin
               // move the short run into the literal store, split at a full token
               iss     = 1'b1;
               cmd_out = '{op: OP_APPEND, value: rv_ff, aux: BYTE_W'(take_n), eos: eos_ff};
               if (go) begin
                  lc_in = lc_sum;
                  rl_in = rl_ff - take_n;
                  if (lc_sum == CNT_W'(TOKEN_MAX)) begin
                     state_in = S_LFLUSH;
                  end
               end
            end
         end
         S_LFLUSH: begin
            iss     = 1'b1;
            cmd_out = '{op: OP_FLUSH, value: rv_ff, aux: '0, eos: eos_ff};
            if (go) begin
               lc_in    = '0;
               state_in = S_CLOSE;
            end
         end
         S_NEWRUN: begin
            rv_in = data_ff;
            rl_in = CNT_W'(1);
            if (eff_min == CNT_W'(1)) begin
               rep_in   = 1'b1;
               state_in = S_EFLUSH;
            end else begin
               ret_final_in = 1'b1;
               state_in     = after_state;
            end
         end
         S_EFLUSH: begin
            iss     = lc_ff != '0;
            cmd_out = '{op: OP_FLUSH, value: rv_ff, aux: '0, eos: eos_ff};
            if (go) begin
               lc_in    = '0;
               state_in = S_ECHUNK;
            end
         end
         S_ECHUNK: begin
            if (rl_ff >= CNT_W'(TOKEN_MAX)) begin
               iss     = 1'b1;
               cmd_out = '{op: OP_REPEAT, value: rv_ff,
                           aux: repeat_header(CNT_W'(TOKEN_MAX)), eos: eos_ff};
               if (go) begin
                  rl_in = rl_ff - CNT_W'(TOKEN_MAX);
               end
            end else begin
               ret_final_in = 1'b1;
               state_in     = after_state;
            end
         end
         S_FINAL: begin
            iss     = lc_ff != '0;
            cmd_out = '{op: OP_FLUSH, value: rv_ff, aux: '0, eos: eos_ff};
            if (go) begin
               lc_in    = '0;
               rv_in    = '0;
               state_in = S_END;
            end
         end
         S_END: begin
            iss = 1'b1;
            if (go) begin
               state_in = req_valid ? S_DECIDE : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         min_run_ff   <= MIN_RUN_RESET;
         ret_final_ff <= 1'b0;
         rv_ff        <= '0;
         rl_ff        <= '0;
         rep_ff       <= 1'b0;
         lc_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         ret_final_ff <= ret_final_in;
         rv_ff        <= rv_in;
         rl_ff        <= rl_in;
         rep_ff       <= rep_in;
         lc_ff        <= lc_in;
         if (csr_wr_en) begin
            min_run_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data_byte;
         eos_ff  <= req_end_of_stream;
      end
   end

endmodule

// ----- hw/rtl/rle_back.sv -----
// Back of the encoder: literal store, group assembly and the result register.
module rle_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  rle_pkg::cmd_type         cmd_in,
   output logic                     cmd_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rle_pkg::lanes_type       rsp_lanes,
   output logic [rle_pkg::LC_W-1:0] rsp_lane_count,
   output logic                     rsp_burst_last,
   output logic                     rsp_stream_done
);
   import rle_pkg::*;

   localparam logic [1:0] B_DISP   = 2'd0;
   localparam logic [1:0] B_APPEND = 2'd1;
   localparam logic [1:0] B_FLUSH  = 2'd2;

   logic [BYTE_W-1:0] lit_mem [LITERAL_DEPTH];

   logic [1:0]        state_ff, state_in;
   logic [LIT_AW-1:0] wptr_ff, wptr_in;
   logic [CNT_W-1:0]  app_left_ff, app_left_in;
   logic [BYTE_W-1:0] app_val_ff, app_val_in;
   logic [LIT_AW-1:0] total_ff, total_in;
   logic [LIT_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LIT_AW-1:0] cons_ff, cons_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [BYTE_W-1:0] rd_data_ff;
   lanes_type         asm_ff, asm_in;
   logic [LC_W-1:0]   fill_ff, fill_in;

   logic              hold_valid_ff;
   lanes_type         hold_lanes_ff;
   logic [LC_W-1:0]   hold_count_ff;

   logic              out_valid_ff;
   lanes_type         out_lanes_ff;
   logic [LC_W-1:0]   out_count_ff;
   logic              out_last_ff;
   logic              out_done_ff;

   logic              can_move, h_room, consume, rd_issue, wr_en;
   logic              last_byte, grp_full;
   lanes_type         asm_with;
   logic              hold_load, end_move, move_go;
   lanes_type         hold_new_lanes;
   logic [LC_W-1:0]   hold_new_count;

   // the hold stage keeps the newest group until it is known whether it ends the word's burst
   assign can_move  = hold_valid_ff && (!out_valid_ff || !rsp_stall);
   assign h_room    = !hold_valid_ff || can_move;
   assign consume   = (state_ff == B_FLUSH) && rd_valid_ff && h_room;
   assign rd_issue  = (state_ff == B_FLUSH) && (rd_ptr_ff < total_ff) &&
                      (!rd_valid_ff || consume);
   assign wr_en     = state_ff == B_APPEND;
   assign last_byte = cons_ff == total_ff - 1'b1;
   assign grp_full  = fill_ff == LC_W'(LANES - 1);
   assign move_go   = (hold_load && hold_valid_ff) || end_move;

   always_comb begin
      asm_with = asm_ff;
      asm_with[fill_ff[LANE_AW-1:0]] = rd_data_ff;
   end

   always_comb begin
      state_in       = state_ff;
      wptr_in        = wptr_ff;
      app_left_in    = app_left_ff;
      app_val_in     = app_val_ff;
      total_in       = total_ff;
      rd_ptr_in      = rd_ptr_ff;
      cons_in        = cons_ff;
      asm_in         = asm_ff;
      fill_in        = fill_ff;
      cmd_pop        = 1'b0;
      hold_load      = 1'b0;
      end_move       = 1'b0;
      hold_new_lanes = '0;
      hold_new_count = '0;
      rd_valid_in    = rd_valid_ff;

      case (state_ff)
         B_DISP: begin
            if (cmd_valid) begin
               case (cmd_in.op)
                  OP_APPEND: begin
                     cmd_pop     = 1'b1;
                     app_val_in  = cmd_in.value;
                     app_left_in = CNT_W'(cmd_in.aux);
                     state_in    = B_APPEND;
                  end
                  OP_REPEAT: begin
                     if (h_room) begin
                        cmd_pop           = 1'b1;
                        hold_load         = 1'b1;
                        hold_new_lanes[0] = cmd_in.aux;
                        hold_new_lanes[1] = cmd_in.value;
                        hold_new_count    = LC_W'(2);
                     end
                  end
                  OP_FLUSH: begin
                     cmd_pop   = 1'b1;
                     asm_in    = '0;
                     asm_in[0] = {1'b0, HDR_W'(wptr_ff - 1'b1)};
                     fill_in   = LC_W'(1);
                     total_in  = wptr_ff;
                     rd_ptr_in = '0;
                     cons_in   = '0;
                     wptr_in   = '0;
                     state_in  = B_FLUSH;
                  end
                  OP_END: begin
                     if (!hold_valid_ff) begin
                        cmd_pop = 1'b1;
                     end else if (can_move) begin
                        cmd_pop  = 1'b1;
                        end_move = 1'b1;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         B_APPEND: begin
            wptr_in     = wptr_ff + 1'b1;
            app_left_in = app_left_ff - 1'b1;
            if (app_left_ff == CNT_W'(1)) begin
               state_in = B_DISP;
            end
         end
         B_FLUSH: begin
            if (rd_issue) begin
               rd_ptr_in   = rd_ptr_ff + 1'b1;
               rd_valid_in = 1'b1;
            end else if (consume) begin
               rd_valid_in = 1'b0;
            end
            if (consume) begin
               cons_in = cons_ff + 1'b1;
               if (grp_full || last_byte) begin
                  hold_load      = 1'b1;
                  hold_new_lanes = asm_with;
                  hold_new_count = fill_ff + 1'b1;
                  asm_in         = '0;
                  fill_in        = '0;
               end else begin
                  asm_in  = asm_with;
                  fill_in = fill_ff + 1'b1;
               end
               if (last_byte) begin
                  state_in = B_DISP;
               end
            end
         end
         default: begin
            state_in = B_DISP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_DISP;
         wptr_ff       <= '0;
         app_left_ff   <= '0;
         rd_ptr_ff     <= '0;
         cons_ff       <= '0;
         total_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         fill_ff       <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         wptr_ff     <= wptr_in;
         app_left_ff <= app_left_in;
         rd_ptr_ff   <= rd_ptr_in;
         cons_ff     <= cons_in;
         total_ff    <= total_in;
         rd_valid_ff <= rd_valid_in;
         fill_ff     <= fill_in;
         if (hold_load) begin
            hold_valid_ff <= 1'b1;
         end else if (end_move) begin
            hold_valid_ff <= 1'b0;
         end
         if (move_go) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      app_val_ff <= app_val_in;
      asm_ff     <= asm_in;
      if (hold_load) begin
         hold_lanes_ff <= hold_new_lanes;
         hold_count_ff <= hold_new_count;
      end
      if (move_go) begin
         out_lanes_ff <= hold_lanes_ff;
         out_count_ff <= hold_count_ff;
         out_last_ff  <= end_move;
         out_done_ff  <= end_move && cmd_in.eos;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lit_mem[wptr_ff] <= app_val_ff;
      end
      if (rd_issue) begin
         rd_data_ff <= lit_mem[rd_ptr_ff];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_lanes       = out_lanes_ff;
   assign rsp_lane_count  = out_count_ff;
   assign rsp_burst_last  = out_last_ff;
   assign rsp_stream_done = out_done_ff;

endmodule

// ----- hw/rtl/run_length_encoder.sv -----
// Top level of the streaming run-length encoder: front, command queue and back.
//
// Streaming run-length encoder. Each accepted word carries one raw byte and an
// end-of-stream flag; each result word carries one group of up to eight compressed
// bytes (lane_0 upward, unused lanes zero), the lane count, burst_last on the final
// group caused by that input byte and stream_done on the final group of the stream.
// Runs of at least min_run equal bytes (register, reset 3, 0 acts as 1, values above
// 16 act as 16) go out as repeat tokens, header 0x80|(count-1) plus the value, at
// most 128 bytes per token; shorter runs collect in a 144-entry literal memory and go
// out as literal tokens, header count-1 plus the bytes, when 128 are held, ahead of a
// repeat run and at end of stream. The front works on one byte at a time and stalls
// the input until it has pushed that byte's last command; it also waits while the
// 4-deep command queue is full. The back drains the queue: it moves a repeat token or
// a byte's end marker on once the result register can take a group, writes the bytes
// of an append into the literal memory, and reads a literal token out through the
// single memory read port. A full literal token stalls the input once the queue
// fills. Write min_run only while the block is idle.
module run_length_encoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [rle_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                       req_end_of_stream,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [rle_pkg::BYTE_W-1:0] rsp_lane_0,
   output logic [rle_pkg::BYTE_W-1:0] rsp_lane_1,
   output logic [rle_pkg::BYTE_W-1:0] rsp_lane_2,
   output logic [rle_pkg::BYTE_W-1:0] rsp_lane_3,
   output logic [rle_pkg::BYTE_W-1:0] rsp_lane_4,
   output logic [rle_pkg::BYTE_W-1:0] rsp_lane_5,
   output logic [rle_pkg::BYTE_W-1:0] rsp_lane_6,
   output logic [rle_pkg::BYTE_W-1:0] rsp_lane_7,
   output logic [rle_pkg::LC_W-1:0]   rsp_lane_count,
   output logic                       rsp_burst_last,
   output logic                       rsp_stream_done,
   input  logic                       csr_wr_en,
   input  logic [rle_pkg::MR_W-1:0]   csr_wr_data
);
   import rle_pkg::*;

   // front to queue
   logic      cmd_push;
   cmd_type   cmd_front;
   logic      cmd_room;
   // queue to back
   cmd_type   cmd_head;
   logic      cmd_valid;
   logic      cmd_pop;
   lanes_type rsp_lanes;

   // classify bytes, track the open run, mirror the literal fill level
   rle_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .cmd_push          (cmd_push),
      .cmd_out           (cmd_front),
      .cmd_room          (cmd_room)
   );

   // decouple front and back so each can stall on its own
   rle_cmd_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_cmd  (cmd_front),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .not_empty (cmd_valid),
      .room      (cmd_room)
   );

   // store literals, build groups, hold the last group until the burst closes
   rle_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (cmd_valid),
      .cmd_in          (cmd_head),
      .cmd_pop         (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_lanes       (rsp_lanes),
      .rsp_lane_count  (rsp_lane_count),
      .rsp_burst_last  (rsp_burst_last),
      .rsp_stream_done (rsp_stream_done)
   );

   // split the group onto the lane ports
   assign rsp_lane_0 = rsp_lanes[0];
   assign rsp_lane_1 = rsp_lanes[1];
   assign rsp_lane_2 = rsp_lanes[2];
   assign rsp_lane_3 = rsp_lanes[3];
   assign rsp_lane_4 = rsp_lanes[4];
   assign rsp_lane_5 = rsp_lanes[5];
   assign rsp_lane_6 = rsp_lanes[6];
   assign rsp_lane_7 = rsp_lanes[7];

   // the front only pushes when the queue has room; a lost command corrupts the stream
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> cmd_room)
      else $error("command pushed into a full queue");

   // every group carries between one and a full set of bytes
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_lane_count != '0 && rsp_lane_count <= LC_W'(LANES)))
      else $error("result group with an illegal lane count");

   // the end of the stream also ends the burst of its input byte
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stream_done) |-> rsp_burst_last)
      else $error("stream_done without burst_last");

   // the top lane stays clear unless the group is full
   a_unused_lane_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_lane_count != LC_W'(LANES)) |-> rsp_lane_7 == '0)
      else $error("unused top lane not zero");

endmodule

// ----- test/run_length_encoder_tb.sv -----
// Self-checking testbench of run_length_encoder: random byte streams against a predictor.
module run_length_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rle_pkg::*;

   localparam time HALF_PERIOD   = 1ns;
   localparam int  RESET_CYCLES  = 7;
   localparam int  MAX_GROUPS    = 20;      // groups one byte may cause
   localparam int  SETTLE_CYCLES = 40;      // short-run close and bookkeeping
   localparam int  TAIL_CYCLES   = 60;
   localparam int  HOLD_CYCLES   = 600;     // long receiver hold-off
   localparam int  CYCLE_LIMIT   = 400000;
   localparam int  REPORT_LIMIT  = 10;

   // one raw input word
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              eos;
   } raw_word_type;

   // one compressed group as it leaves the block
   typedef struct packed {
      lanes_type       lanes;
      logic [LC_W-1:0] count;
      logic            burst_last;
      logic            stream_done;
   } enc_group_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid         = 1'b0;
   logic              req_stall;
   logic [BYTE_W-1:0] req_data_byte     = '0;
   logic              req_end_of_stream = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall         = 1'b0;
   logic [BYTE_W-1:0] rsp_lane_0, rsp_lane_1, rsp_lane_2, rsp_lane_3;
   logic [BYTE_W-1:0] rsp_lane_4, rsp_lane_5, rsp_lane_6, rsp_lane_7;
   logic [LC_W-1:0]   rsp_lane_count;
   logic              rsp_burst_last;
   logic              rsp_stream_done;
   logic              csr_wr_en         = 1'b0;
   logic [MR_W-1:0]   csr_wr_data       = '0;

   run_length_encoder u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_lane_0        (rsp_lane_0),
      .rsp_lane_1        (rsp_lane_1),
      .rsp_lane_2        (rsp_lane_2),
      .rsp_lane_3        (rsp_lane_3),
      .rsp_lane_4        (rsp_lane_4),
      .rsp_lane_5        (rsp_lane_5),
      .rsp_lane_6        (rsp_lane_6),
      .rsp_lane_7        (rsp_lane_7),
      .rsp_lane_count    (rsp_lane_count),
      .rsp_burst_last    (rsp_burst_last),
      .rsp_stream_done   (rsp_stream_done),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ------------------------------------------------------------------
   // Encoder predictor: own copy of the run, the literal memory and the
   // min_run register. Groups caused by one byte collect in step_groups.
   // ------------------------------------------------------------------
   logic [BYTE_W-1:0] enc_value;
   int                enc_len;
   bit                enc_repeat;
   logic [BYTE_W-1:0] lit_mem [LITERAL_DEPTH];
   int                lit_count;
   logic [MR_W-1:0]   enc_min_run;

   enc_group_type step_groups [MAX_GROUPS];
   int            step_count;
   int            lane_fill;
   bit            overflow_drop;

   enc_group_type due_groups [$];   // groups still owed by the block

   // Place one compressed byte; a token never shares a group with another.
   function automatic void pack_lane_byte(logic [BYTE_W-1:0] b, bit token_start);
      if (token_start || lane_fill >= LANES) begin
         if (step_count >= MAX_GROUPS) begin
            overflow_drop = 1'b1;
            return;
         end
         step_groups[step_count] = '0;
         step_count++;
         lane_fill     = 0;
         overflow_drop = 1'b0;
      end else if (overflow_drop) begin
         return;
      end
      step_groups[step_count-1].lanes[lane_fill] = b;
      lane_fill++;
      step_groups[step_count-1].count = LC_W'(lane_fill);
   endfunction

   function automatic void emit_repeat_token(int count);
      pack_lane_byte(REPEAT_FLAG | {1'b0, HDR_W'(count - 1)}, 1'b1);
      pack_lane_byte(enc_value, 1'b0);
   endfunction

   function automatic void drain_literals();
      if (lit_count == 0)
         return;
      pack_lane_byte({1'b0, HDR_W'(lit_count - 1)}, 1'b1);
      for (int k = 0; k < lit_count; k++)
         pack_lane_byte(lit_mem[k], 1'b0);
      lit_count = 0;
   endfunction

   function automatic void store_literal(logic [BYTE_W-1:0] b);
      if (lit_count < LITERAL_DEPTH) begin
         lit_mem[lit_count] = b;
         lit_count++;
      end
      if (lit_count >= TOKEN_MAX)
         drain_literals();
   endfunction

   function automatic void start_repeat();
      enc_repeat = 1'b1;
      drain_literals();
      while (enc_len >= TOKEN_MAX) begin
         emit_repeat_token(TOKEN_MAX);
         enc_len -= TOKEN_MAX;
      end
   endfunction

   function automatic void close_open_run();
      if (enc_repeat) begin
         if (enc_len > 0)
            emit_repeat_token(enc_len);
      end else begin
         for (int k = 0; k < enc_len; k++)
            store_literal(enc_value);
      end
      enc_len    = 0;
      enc_repeat = 1'b0;
   endfunction

   // Advance the predictor by one accepted byte and queue the groups it owes.
   function automatic void encode_byte(logic [BYTE_W-1:0] b, logic eos);
      int eff_min;
      bit run_open;
      eff_min  = enc_min_run;
      if (eff_min < 1)
         eff_min = 1;
      if (eff_min > MIN_RUN_LIMIT)
         eff_min = MIN_RUN_LIMIT;
      run_open      = enc_len > 0 || enc_repeat;
      step_count    = 0;
      lane_fill     = 0;
      overflow_drop = 1'b0;

      if (run_open && b == enc_value) begin
         enc_len++;
         if (!enc_repeat) begin
            if (enc_len >= eff_min)
               start_repeat();
         end else if (enc_len >= TOKEN_MAX) begin
            emit_repeat_token(TOKEN_MAX);
            enc_len -= TOKEN_MAX;
         end
      end else begin
         close_open_run();
         enc_value = b;
         enc_len   = 1;
         if (eff_min <= 1)
            start_repeat();
      end

      if (eos) begin
         close_open_run();
         drain_literals();
         enc_value = '0;
      end

      if (step_count > 0) begin
         step_groups[step_count-1].burst_last  = 1'b1;
         step_groups[step_count-1].stream_done = eos;
      end
      for (int k = 0; k < step_count; k++)
         due_groups.insert(due_groups.size(), step_groups[k]);
   endfunction

   // ------------------------------------------------------------------
   // Stimulus store and generators
   // ------------------------------------------------------------------
   raw_word_type      raw_queue [$];
   int                words_queued = 0;
   int                words_taken  = 0;
   logic [BYTE_W-1:0] last_queued  = '0;
   logic [BYTE_W-1:0] corner_bytes [4] = '{8'h00, 8'hff, 8'h80, 8'h7f};
   int                settings_used = 0;

   function automatic void queue_word(logic [BYTE_W-1:0] b, logic eos);
      raw_word_type w;
      w.data = b;
      w.eos  = eos;
      raw_queue.insert(raw_queue.size(), w);
      words_queued++;
      last_queued = b;
   endfunction

   // Runs of random value and length; mostly short, some up to max_len.
   function automatic void queue_random_stream(int n_words, int max_len, bit mid_eos,
                                               bit end_eos);
      int                left;
      int                len;
      logic [BYTE_W-1:0] val;
      bit                eos_here;
      left = n_words;
      while (left > 0) begin
         len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, max_len)
                                           : $urandom_range(1, 3);
         if (len > left)
            len = left;
         val = ($urandom_range(0, 3) == 0) ? corner_bytes[$urandom_range(0, 3)]
                                           : BYTE_W'($urandom_range(0, 255));
         // keep runs apart so run lengths stay as chosen
         if (val == last_queued)
            val = val ^ 8'h01;
         eos_here = mid_eos && ($urandom_range(0, 9) == 0);
         left -= len;
         for (int k = 0; k < len; k++)
            queue_word(val, (k == len - 1) && (eos_here || (left == 0 && end_eos)));
      end
   endfunction

   // ------------------------------------------------------------------
   // Driver: bursts of random length, random gaps; hold the word while
   // stalled, predict at acceptance.
   // ------------------------------------------------------------------
   raw_word_type offer_word;
   int           burst_left = 0;
   int           gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid         <= 1'b0;
         req_data_byte     <= '0;
         req_end_of_stream <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            encode_byte(req_data_byte, req_end_of_stream);
            words_taken++;
         end
         if (gap_left > 0 || raw_queue.size() == 0) begin
            if (gap_left > 0)
               gap_left--;
            req_valid <= 1'b0;
         end else begin
            offer_word = raw_queue.pop_front();
            req_valid         <= 1'b1;
            req_data_byte     <= offer_word.data;
            req_end_of_stream <= offer_word.eos;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               // end of burst: pick the next length and the gap after it
               burst_left = $urandom_range(0, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver: switches among random stall patterns; on request a
   // long hold-off, counted here, lets the block back up into its input.
   // ------------------------------------------------------------------
   int rx_mode       = 0;
   int rx_mode_left  = 0;
   int rx_hold_left  = 0;
   int holds_done    = 0;
   int hold_requests = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_done < hold_requests) begin
         holds_done++;
         rx_hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 80);
         end else begin
            rx_mode_left--;
         end
         case (rx_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Monitor: compare every accepted group with the oldest one owed.
   // ------------------------------------------------------------------
   enc_group_type seen_group;
   enc_group_type want_group;
   int            groups_checked = 0;
   int            errors         = 0;

   function automatic void note_error(string msg);
      errors++;
      if (errors <= REPORT_LIMIT)
         $display("ERROR: %s", msg);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_group.lanes       = {rsp_lane_7, rsp_lane_6, rsp_lane_5, rsp_lane_4,
                                   rsp_lane_3, rsp_lane_2, rsp_lane_1, rsp_lane_0};
         seen_group.count       = rsp_lane_count;
         seen_group.burst_last  = rsp_burst_last;
         seen_group.stream_done = rsp_stream_done;
         if (due_groups.size() == 0) begin
            note_error($sformatf("group %0d arrived with nothing owed: lanes %h count %0d",
                                 groups_checked, seen_group.lanes, seen_group.count));
         end else begin
            want_group = due_groups.pop_front();
            if (seen_group !== want_group)
               note_error($sformatf({"group %0d: expected lanes %h count %0d last %b done %b,",
                                     " got lanes %h count %0d last %b done %b"},
                                    groups_checked, want_group.lanes, want_group.count,
                                    want_group.burst_last, want_group.stream_done,
                                    seen_group.lanes, seen_group.count,
                                    seen_group.burst_last, seen_group.stream_done));
         end
         groups_checked++;
      end
   end

   // ------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------
   int cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d groups still owed",
                  cycle_count, due_groups.size());
         $display("run_length_encoder regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   // Hold the sender until every word is in and every group is out, then
   // let the front finish any run bookkeeping that owes no group.
   task automatic settle_block();
      while (words_taken != words_queued || due_groups.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_min_run(logic [MR_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      enc_min_run = value;
      settings_used++;
   endtask

   initial begin
      enc_value   = '0;
      enc_len     = 0;
      enc_repeat  = 1'b0;
      lit_count   = 0;
      enc_min_run = MIN_RUN_RESET;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed, min_run at its reset value: literals flushed ahead of a
      // repeat run, repeat closed by end of stream, extreme byte values.
      queue_word(8'h00, 1'b0);
      queue_word(8'hff, 1'b0);
      queue_word(8'h7f, 1'b0);
      queue_word(8'h7f, 1'b0);
      repeat (4) queue_word(8'h80, 1'b0);
      queue_word(8'h01, 1'b1);
      // single-byte stream
      queue_word(8'hc3, 1'b1);
      // end of stream while in repeat mode
      repeat (3) queue_word(8'h5a, 1'b0);
      queue_word(8'h5a, 1'b1);
      // end of stream with only literals pending
      queue_word(8'h12, 1'b0);
      queue_word(8'h34, 1'b1);
      settle_block();

      // Every run is a repeat token, even a single byte.
      set_min_run(5'd1);
      queue_word(8'h99, 1'b0);
      queue_word(8'h99, 1'b0);
      queue_word(8'h66, 1'b1);
      queue_word(8'hfe, 1'b0);
      queue_word(8'hef, 1'b1);
      settle_block();

      // Literal-only stream long enough to fill a 128-byte literal token;
      // the receiver holds off meanwhile.
      set_min_run(5'd16);
      hold_requests <= hold_requests + 1;
      queue_random_stream(130, 12, 1'b0, 1'($urandom_range(0, 1)));
      settle_block();

      // One run of at least a full repeat chunk, then short random runs.
      set_min_run(5'd2);
      begin
         logic [BYTE_W-1:0] long_value;
         long_value = BYTE_W'($urandom_range(0, 255));
         repeat ($urandom_range(TOKEN_MAX, TOKEN_MAX + 12)) queue_word(long_value, 1'b0);
      end
      queue_random_stream(15, 5, 1'b1, 1'b1);
      settle_block();

      // Zero acts as one: dense output, so a second hold-off backs up the
      // input. Leave the stream open so the next setting lands mid-stream.
      set_min_run(5'd0);
      hold_requests <= hold_requests + 1;
      queue_random_stream(16, 4, 1'b1, 1'b0);
      settle_block();

      // Out-of-range values saturate at the limit.
      set_min_run(5'd31);
      queue_random_stream(16, 20, 1'b1, 1'b0);
      settle_block();

      set_min_run(5'd17);
      queue_random_stream(16, 18, 1'b1, 1'b1);
      settle_block();

      set_min_run(MIN_RUN_RESET);
      queue_random_stream(16, 6, 1'b1, 1'b0);
      settle_block();

      set_min_run(MR_W'($urandom_range(0, 31)));
      queue_random_stream(16, 10, 1'b1, 1'b1);

      while (words_taken != words_queued || due_groups.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d raw bytes and %0d compressed groups over %0d min_run settings,",
               words_taken, groups_checked, settings_used);
      $display("with %0d long receiver hold-offs and %0d mismatches", holds_done, errors);
      if (errors == 0)
         $display("run_length_encoder regression: pass");
      else
         $display("run_length_encoder regression: fail");
      $finish;
   end

endmodule
